// ----- design/box_blur_3x3_rgb_defines.svh -----
// assertion helpers for the box blur block
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BB3_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bb3_pkg.sv -----
package bb3_pkg;

  // configuration port
  localparam int CFG_W  = 12;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;

  // input word kinds
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // channel slots inside a packed pixel
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  // per-item control carried down the pipe
  typedef struct packed {
    logic pix;
    logic flush;
    logic emit_main;
    logic border;
    logic emit_corner;
    logic emit_last;
    logic flush_end;
  } bb3_ctl_t;

endpackage

// ----- design/bb3_ram.sv -----
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_a,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read returns the old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ----- design/box_blur_3x3_rgb.sv -----
// 3x3 box blur over an rgb pixel stream in raster order
//
// input channel (in_valid/in_ready): one word per pixel (in_cmd pixel) and,
// after the last pixel of a frame, image_width flush words (in_cmd flush)
// that drain the bottom row. a flush word while pixels are expected and a
// pixel word while draining are dropped without a result.
// output channel (out_valid/out_ready): blurred words in raster order, the
// stream lagging the input by one row plus one pixel; interior channels are
// the truncated mean of the 3x3 window, border pixels pass through.
// the last pixel of a frame gives two words; out_last_of_step marks the last
// word an input word causes.
// path: a result word passes the line buffer read, the window sum and the
// divide by 9 in turn, then is pushed into the output queue.
// throughput: one input word per cycle while in_ready is high; each line
// buffer does one read at the column and one write back per cycle, its
// second read port serves the row-end corner or the flush column.
// config: apb registers image_width at 0x0 and image_height at 0x4.
// reset: counters clear, geometry returns to 640x480; line buffer contents
// are not cleared (no clearing pass).
// stall: results wait in an 8-word queue; in_ready drops while the queue
// plus the words still in the pipe could overfill it.

`include "box_blur_3x3_rgb_defines.svh"

module box_blur_3x3_rgb import bb3_pkg::*; #(
  parameter int MAX_WIDTH    = 2048,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  // input words
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [CHANNEL_BITS-1:0] in_red_in,
  input  logic [CHANNEL_BITS-1:0] in_green_in,
  input  logic [CHANNEL_BITS-1:0] in_blue_in,
  // result words
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] out_red_out,
  output logic [CHANNEL_BITS-1:0] out_green_out,
  output logic [CHANNEL_BITS-1:0] out_blue_out,
  output logic                    out_row_end,
  output logic                    out_frame_end,
  output logic                    out_last_of_step
);

  localparam int CB      = CHANNEL_BITS;
  localparam int PIX_W   = 3 * CB;
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WX_W    = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  // column sum of three values, window sum of nine
  localparam int CS_W    = CB + 2;
  localparam int SUM_W   = CB + 4;
  // floor(x/9) = (x * RECIP) >> DIV_K for every x below 2**SUM_W
  localparam int DIV_K   = SUM_W + 3;
  localparam int RECIP_W = SUM_W + 1;
  localparam int RECIP   = ((1 << DIV_K) + 8) / 9;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef logic [2:0][CB-1:0]    pix_t;
  typedef logic [2:0][CS_W-1:0]  cs_t;
  typedef logic [2:0][SUM_W-1:0] sum_t;

  typedef struct packed {
    pix_t pix;
    logic row_end;
    logic frame_end;
    logic last;
  } out_word_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // effective geometry, clamped to the supported range
  // ---------------------------------------------------------------------
  logic [WX_W-1:0]  width_x, w_eff;
  logic [COL_W-1:0] wm1;
  logic [CFG_W-1:0] h_eff, hm1;

  assign width_x = WX_W'(width_r);

  always_comb begin
    if (width_x < WX_W'(MIN_DIM)) begin
      w_eff = WX_W'(MIN_DIM);
    end else if (width_x > WX_W'(MAX_WIDTH)) begin
      w_eff = WX_W'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end
  end

  assign wm1   = COL_W'(w_eff - WX_W'(1));
  assign h_eff = (height_r < MIN_DIM) ? MIN_DIM : height_r;
  assign hm1   = h_eff - CFG_W'(1);

  // ---------------------------------------------------------------------
  // stage a: accept, position counters, line buffer read
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0] flush_cnt_r, flush_cnt_nxt;
  logic [CFG_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0] c_cur, f_cur;
  logic             draining;
  logic             in_acc;
  cmd_t             cmd;
  bb3_ctl_t         ctl_a;
  pix_t             p_in;

  // a row count at or past the height means the bottom row is draining
  assign draining = (row_cnt_r >= h_eff);
  // counts past a narrowed width act as the last column
  assign c_cur    = (col_cnt_r > wm1) ? wm1 : col_cnt_r;
  assign f_cur    = (flush_cnt_r > wm1) ? wm1 : flush_cnt_r;

  assign in_acc = in_valid & in_ready;
  assign cmd    = cmd_t'(in_cmd);

  assign p_in[CH_R] = in_red_in;
  assign p_in[CH_G] = in_green_in;
  assign p_in[CH_B] = in_blue_in;

  always_comb begin
    ctl_a.pix         = in_acc & ~draining & (cmd == CMD_PIXEL);
    ctl_a.flush       = in_acc & draining & (cmd == CMD_FLUSH);
    // output pixel sits one row up and one column left of the input
    ctl_a.emit_main   = (row_cnt_r != '0) && (c_cur != '0);
    // top row or left column of the output; other borders never land here
    ctl_a.border      = (row_cnt_r == CFG_W'(1)) || (c_cur == COL_W'(1));
    // start of a row emits the last pixel of the row two above
    ctl_a.emit_corner = (row_cnt_r >= CFG_W'(2)) && (c_cur == '0);
    ctl_a.emit_last   = (row_cnt_r == hm1) && (c_cur == wm1);
    ctl_a.flush_end   = (f_cur == wm1);
  end

  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    flush_cnt_nxt = flush_cnt_r;
    if (ctl_a.pix) begin
      priority if (ctl_a.emit_last) begin
        row_cnt_nxt   = h_eff;
        col_cnt_nxt   = '0;
        flush_cnt_nxt = '0;
      end else if (c_cur == wm1) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + CFG_W'(1);
      end else begin
        col_cnt_nxt = c_cur + COL_W'(1);
      end
    end else if (ctl_a.flush) begin
      if (ctl_a.flush_end) begin
        col_cnt_nxt   = '0;
        row_cnt_nxt   = '0;
        flush_cnt_nxt = '0;
      end else begin
        flush_cnt_nxt = f_cur + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // line buffers: older holds row r-2, newer holds row r-1
  // ---------------------------------------------------------------------
  logic             vB_r;
  bb3_ctl_t         ctlB_r;
  logic [COL_W-1:0] cB_r;
  pix_t             pB_r;
  logic             lb_we;
  logic [PIX_W-1:0] older_qa, older_qb, newer_qa, newer_qb;
  pix_t             o_c, n_c, corner, fl;

  // forwarding from the item one ahead, whose write lands on our read edge
  logic fwd_c_r, fwd_corner_r, fwd_fl_r;
  logic fwd_c_nxt, fwd_corner_nxt, fwd_fl_nxt;
  pix_t fwd_old_r, fwd_new_r;

  assign lb_we = vB_r & ctlB_r.pix;

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lb_older (
    .clk     (clk),
    .we      (lb_we),
    .waddr   (cB_r),
    .wdata   (n_c),
    .raddr_a (c_cur),
    .raddr_b (wm1),
    .rdata_a (older_qa),
    .rdata_b (older_qb)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lb_newer (
    .clk     (clk),
    .we      (lb_we),
    .waddr   (cB_r),
    .wdata   (pB_r),
    .raddr_a (c_cur),
    .raddr_b (f_cur),
    .rdata_a (newer_qa),
    .rdata_b (newer_qb)
  );

  assign fwd_c_nxt      = lb_we && (cB_r == c_cur);
  assign fwd_corner_nxt = lb_we && (cB_r == wm1);
  assign fwd_fl_nxt     = lb_we && (cB_r == f_cur);

  // ---------------------------------------------------------------------
  // stage b: window update and sums, line buffer write back
  // ---------------------------------------------------------------------
  cs_t  csa_r, csb_r, newcs;
  pix_t midb_r;
  sum_t sum_b;

  assign o_c    = fwd_c_r      ? fwd_old_r : pix_t'(older_qa);
  assign n_c    = fwd_c_r      ? fwd_new_r : pix_t'(newer_qa);
  assign corner = fwd_corner_r ? fwd_old_r : pix_t'(older_qb);
  assign fl     = fwd_fl_r     ? fwd_new_r : pix_t'(newer_qb);

  // window kept as column sums plus the middle row
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      newcs[ch] = CS_W'(o_c[ch]) + CS_W'(n_c[ch]) + CS_W'(pB_r[ch]);
      sum_b[ch] = SUM_W'(csa_r[ch]) + SUM_W'(csb_r[ch]) + SUM_W'(newcs[ch]);
    end
  end

  // stage c inputs
  logic vC_r, res0_v_r, res1_v_r;
  logic res0_v_nxt, res1_v_nxt;
  logic use_mean_r, row_end0_r, frame_end0_r;
  sum_t sumC_r;
  pix_t pix0C_r, pix1C_r, pix0_nxt;

  assign res0_v_nxt = ctlB_r.flush | (ctlB_r.pix & (ctlB_r.emit_main | ctlB_r.emit_corner));
  assign res1_v_nxt = ctlB_r.pix & ctlB_r.emit_last;

  always_comb begin
    priority if (ctlB_r.flush) begin
      pix0_nxt = fl;
    end else if (ctlB_r.emit_main) begin
      pix0_nxt = midb_r;
    end else begin
      pix0_nxt = corner;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: divide by nine, push into the output queue
  // ---------------------------------------------------------------------
  pix_t      mean_c;
  out_word_t word0, word1;
  logic      wr0, wr1;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_c[ch] = CB'((PROD_W'(sumC_r[ch]) * PROD_W'(RECIP)) >> DIV_K);
    end
  end

  always_comb begin
    word0.pix       = use_mean_r ? mean_c : pix0C_r;
    word0.row_end   = row_end0_r;
    word0.frame_end = frame_end0_r;
    word0.last      = ~res1_v_r;
    // the extra word of the frame's last pixel closes the next-to-last row
    word1.pix       = pix1C_r;
    word1.row_end   = 1'b1;
    word1.frame_end = 1'b0;
    word1.last      = 1'b1;
  end

  assign wr0 = vC_r & res0_v_r;
  assign wr1 = vC_r & res1_v_r;

  // ---------------------------------------------------------------------
  // output queue
  // ---------------------------------------------------------------------
  out_word_t          fifo_mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [FIFO_AW-1:0] wr_ptr_nxt, rd_ptr_nxt;
  logic [FIFO_CW-1:0] fifo_cnt_r, fifo_cnt_nxt, n_wr;
  logic [FIFO_CW:0]   need, fifo_fill;
  logic               rd;
  out_word_t          head;

  assign n_wr      = FIFO_CW'(wr0) + FIFO_CW'(wr1);
  assign wr_ptr_p1 = wr_ptr_r + FIFO_AW'(1);
  assign out_valid = (fifo_cnt_r != '0);
  assign rd        = out_valid & out_ready;
  assign head      = fifo_mem_r[rd_ptr_r];

  assign wr_ptr_nxt   = wr_ptr_r + FIFO_AW'(n_wr);
  assign rd_ptr_nxt   = rd_ptr_r + FIFO_AW'(rd);
  assign fifo_cnt_nxt = fifo_cnt_r + n_wr - FIFO_CW'(rd);
  assign fifo_fill    = {1'b0, fifo_cnt_r} + {1'b0, n_wr};

  // every word in the pipe holds room for two results
  always_comb begin
    need = {1'b0, fifo_cnt_r} + (FIFO_CW+1)'(2);
    if (vB_r) begin
      need = need + (FIFO_CW+1)'(2);
    end
    if (vC_r) begin
      need = need + (FIFO_CW+1)'(2);
    end
  end

  assign in_ready = (need <= (FIFO_CW+1)'(FIFO_DEPTH));

  assign out_red_out      = head.pix[CH_R];
  assign out_green_out    = head.pix[CH_G];
  assign out_blue_out     = head.pix[CH_B];
  assign out_row_end      = head.row_end;
  assign out_frame_end    = head.frame_end;
  assign out_last_of_step = head.last;

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      flush_cnt_r <= '0;
      vB_r        <= 1'b0;
      ctlB_r      <= '0;
      vC_r        <= 1'b0;
      res0_v_r    <= 1'b0;
      res1_v_r    <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fifo_cnt_r  <= '0;
    end else begin
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      flush_cnt_r <= flush_cnt_nxt;
      vB_r        <= ctl_a.pix | ctl_a.flush;
      ctlB_r      <= ctl_a;
      vC_r        <= vB_r;
      res0_v_r    <= res0_v_nxt;
      res1_v_r    <= res1_v_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      fifo_cnt_r  <= fifo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    // stage b payload
    cB_r         <= c_cur;
    pB_r         <= p_in;
    fwd_c_r      <= fwd_c_nxt;
    fwd_corner_r <= fwd_corner_nxt;
    fwd_fl_r     <= fwd_fl_nxt;
    fwd_old_r    <= n_c;
    fwd_new_r    <= pB_r;
    // window shifts one column per pixel
    if (lb_we) begin
      csa_r  <= csb_r;
      csb_r  <= newcs;
      midb_r <= n_c;
    end
    // stage c payload
    sumC_r       <= sum_b;
    pix0C_r      <= pix0_nxt;
    pix1C_r      <= n_c;
    use_mean_r   <= ctlB_r.pix & ctlB_r.emit_main & ~ctlB_r.border;
    row_end0_r   <= ctlB_r.flush ? ctlB_r.flush_end : ctlB_r.emit_corner;
    frame_end0_r <= ctlB_r.flush & ctlB_r.flush_end;
    // queue storage
    if (wr0) begin
      fifo_mem_r[wr_ptr_r] <= word0;
    end
    if (wr1) begin
      fifo_mem_r[wr_ptr_p1] <= word1;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `BB3_ASSERT_IMPL(a_fifo_no_overflow, wr0, fifo_fill <= (FIFO_CW+1)'(FIFO_DEPTH), "queue overflow")
  `BB3_ASSERT_IMPL(a_stall_has_cause, !in_ready, fifo_cnt_r != '0 || vB_r || vC_r, "stuck stall")
  `BB3_ASSERT_NEXT(a_last_pixel_drains, ctl_a.pix && ctl_a.emit_last, draining, "no drain")

endmodule
